// ----- rtl/core/jvsv_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jvsv_pkg
// Types, codes and character helpers shared by the JSON value stream validator.
// ----------------------------------------------------------------------------
package jvsv_pkg;

	localparam int STACK_DEPTH_DEF = 64;
	localparam int CH_W  = 16;
	localparam int ERR_W = 4;
	localparam int NEST_W = 7;

	typedef enum logic [19:0] {
		PH_IDLE          = 20'h00001,
		PH_VALUE         = 20'h00002,
		PH_VAL_OR_ACLOSE = 20'h00004,
		PH_KEY_OR_OCLOSE = 20'h00008,
		PH_KEY           = 20'h00010,
		PH_COLON         = 20'h00020,
		PH_AFTER         = 20'h00040,
		PH_STR           = 20'h00080,
		PH_ESC           = 20'h00100,
		PH_HEX           = 20'h00200,
		PH_NSIGN         = 20'h00400,
		PH_NINT          = 20'h00800,
		PH_NFRAC0        = 20'h01000,
		PH_NFRAC         = 20'h02000,
		PH_NEXP0         = 20'h04000,
		PH_NEXPS         = 20'h08000,
		PH_NEXP          = 20'h10000,
		PH_LIT_T         = 20'h20000,
		PH_LIT_F         = 20'h40000,
		PH_LIT_N         = 20'h80000
	} phase_t;

	typedef enum logic [ERR_W-1:0] {
		ERR_NONE       = 4'd0,
		ERR_EXP_STRING = 4'd1,
		ERR_UNTERM_STR = 4'd2,
		ERR_BAD_ESCAPE = 4'd3,
		ERR_BAD_NUMBER = 4'd4,
		ERR_BAD_NULL   = 4'd5,
		ERR_BAD_BOOL   = 4'd6,
		ERR_NO_COLON   = 4'd7,
		ERR_ARRAY_END  = 4'd8,
		ERR_OBJECT_END = 4'd9,
		ERR_VALUE_OVF  = 4'd10
	} err_t;

	localparam logic [CH_W-1:0] CH_FF = 16'd12;
	localparam logic [CH_W-1:0] CH_BS = 16'd8;

	typedef struct packed {
		phase_t          phase;
		logic [CH_W-1:0] hex_accum;
		logic [1:0]      hex_count;
		logic [2:0]      lit_idx;
		logic            in_key;
		err_t            err;
	} state_t;

	typedef struct packed {
		logic            char_valid;
		logic [CH_W-1:0] char_value;
		logic            char_is_key;
		logic            string_end;
		logic            value_done;
		err_t            error_code;
	} res_t;

	typedef struct packed {
		logic push;
		logic pop;
		logic kind;
	} stack_op_t;

	function automatic logic is_ws(input logic [CH_W-1:0] c);
		return c == 16'h20 || c == 16'h09 || c == 16'h0D || c == 16'h0A;
	endfunction

	function automatic logic is_digit(input logic [CH_W-1:0] c);
		return c >= 16'h30 && c <= 16'h39;
	endfunction

	// Bit 4 set marks a valid hex digit, bits 3:0 hold its value.
	function automatic logic [4:0] hex_val(input logic [CH_W-1:0] c);
		logic [CH_W-1:0] d;
		d = '0;
		if (c >= 16'h30 && c <= 16'h39) begin
			d = c - 16'h30;
			return {1'b1, d[3:0]};
		end
		if (c >= 16'h41 && c <= 16'h46) begin
			d = c - 16'h37;
			return {1'b1, d[3:0]};
		end
		if (c >= 16'h61 && c <= 16'h66) begin
			d = c - 16'h57;
			return {1'b1, d[3:0]};
		end
		return 5'd0;
	endfunction

	function automatic logic [7:0] lit_char(input phase_t p, input logic [2:0] i);
		logic [7:0] r;
		r = 8'h00;
		case (p)
			PH_LIT_T: begin
				case (i)
					3'd0: r = "t";
					3'd1: r = "r";
					3'd2: r = "u";
					3'd3: r = "e";
					default: r = 8'h00;
				endcase
			end
			PH_LIT_F: begin
				case (i)
					3'd0: r = "f";
					3'd1: r = "a";
					3'd2: r = "l";
					3'd3: r = "s";
					3'd4: r = "e";
					default: r = 8'h00;
				endcase
			end
			default: begin
				case (i)
					3'd0: r = "n";
					3'd1: r = "u";
					3'd2: r = "l";
					3'd3: r = "l";
					default: r = 8'h00;
				endcase
			end
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/core/jvsv_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jvsv_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module jvsv_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH > 1 ? DEPTH : 2)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ----- rtl/core/jvsv_step.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jvsv_step
// Next-state and result logic for one character of the text stream.
// ----------------------------------------------------------------------------
module jvsv_step import jvsv_pkg::*; #(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF,
	localparam int DW = $clog2(STACK_DEPTH + 1)
) (
	input  state_t          st,
	input  wire logic [DW-1:0] depth,
	input  wire logic       top,
	input  wire logic       below,
	input  wire logic [CH_W-1:0] ch,
	input  wire logic       last,
	output state_t          st_nxt,
	output logic [DW-1:0]   depth_nxt,
	output logic            top_nxt,
	output stack_op_t       op,
	output res_t            res
);

	localparam logic [DW-1:0] SD = DW'(STACK_DEPTH);

	always_comb begin
		phase_t          p;
		phase_t          np;
		err_t            err;
		logic [DW-1:0]   dn;
		logic            tn;
		logic [4:0]      hv;
		logic [CH_W-1:0] acc;
		logic            num_end;
		logic            c_e;

		p   = st.phase;
		np  = st.phase;
		err = ERR_NONE;
		dn  = depth;
		tn  = top;
		hv  = hex_val(ch);
		acc = {st.hex_accum[CH_W-5:0], hv[3:0]};
		c_e = ch == 16'h65 || ch == 16'h45;
		num_end = 1'b0;
		st_nxt = st;
		op  = '0;
		res = '0;

		if (st.err == ERR_NONE) begin
			// A character that cannot continue a complete number ends it and is
			// then handled in the phase that follows the value.
			num_end = (p == PH_NINT && !is_digit(ch) && ch != 16'h2E && !c_e) ||
				(p == PH_NFRAC && !is_digit(ch) && !c_e) ||
				(p == PH_NEXP && !is_digit(ch));
			if (num_end) begin
				if (depth == '0) begin
					res.value_done = 1'b1;
					p = PH_IDLE;
				end else begin
					p = PH_AFTER;
				end
			end
			np = p;

			case (p)
				PH_IDLE, PH_VALUE, PH_VAL_OR_ACLOSE: begin
					if (!is_ws(ch)) begin
						if (p == PH_VAL_OR_ACLOSE && ch == 16'h5D) begin
							op.pop = 1'b1;
						end else if (ch == 16'h7B || ch == 16'h5B) begin
							if (depth >= SD) begin
								err = ERR_VALUE_OVF;
							end else begin
								op.push = 1'b1;
								op.kind = ch == 16'h7B;
								dn = depth + 1'b1;
								tn = op.kind;
								np = op.kind ? PH_KEY_OR_OCLOSE : PH_VAL_OR_ACLOSE;
							end
						end else if (ch == 16'h22) begin
							st_nxt.in_key = 1'b0;
							np = PH_STR;
						end else if (ch == 16'h74) begin
							st_nxt.lit_idx = 3'd1;
							np = PH_LIT_T;
						end else if (ch == 16'h66) begin
							st_nxt.lit_idx = 3'd1;
							np = PH_LIT_F;
						end else if (ch == 16'h6E) begin
							st_nxt.lit_idx = 3'd1;
							np = PH_LIT_N;
						end else if (ch == 16'h2D) begin
							np = PH_NSIGN;
						end else if (is_digit(ch)) begin
							np = PH_NINT;
						end else begin
							err = ERR_VALUE_OVF;
						end
					end
				end
				PH_KEY_OR_OCLOSE, PH_KEY: begin
					if (!is_ws(ch)) begin
						if (p == PH_KEY_OR_OCLOSE && ch == 16'h7D) begin
							op.pop = 1'b1;
						end else if (ch == 16'h22) begin
							st_nxt.in_key = 1'b1;
							np = PH_STR;
						end else begin
							err = ERR_EXP_STRING;
						end
					end
				end
				PH_COLON: begin
					if (!is_ws(ch)) begin
						if (ch == 16'h3A) begin
							np = PH_VALUE;
						end else begin
							err = ERR_NO_COLON;
						end
					end
				end
				PH_AFTER: begin
					if (!is_ws(ch)) begin
						if (ch == 16'h2C) begin
							np = (depth != '0 && top) ? PH_KEY : PH_VALUE;
						end else if (depth != '0 && top) begin
							if (ch == 16'h7D) begin
								op.pop = 1'b1;
							end else begin
								err = ERR_OBJECT_END;
							end
						end else begin
							if (ch == 16'h5D) begin
								op.pop = 1'b1;
							end else begin
								err = ERR_ARRAY_END;
							end
						end
					end
				end
				PH_STR: begin
					if (ch == 16'h5C) begin
						np = PH_ESC;
					end else if (ch == 16'h22) begin
						res.string_end = 1'b1;
						if (st.in_key) begin
							st_nxt.in_key = 1'b0;
							np = PH_COLON;
						end else if (depth == '0) begin
							res.value_done = 1'b1;
							np = PH_IDLE;
						end else begin
							np = PH_AFTER;
						end
					end else begin
						res.char_valid = 1'b1;
						res.char_value = ch;
					end
				end
				PH_ESC: begin
					np = PH_STR;
					res.char_valid = 1'b1;
					case (ch)
						16'h22, 16'h5C, 16'h2F: res.char_value = ch;
						16'h62: res.char_value = CH_BS;
						16'h66: res.char_value = CH_FF;
						16'h6E: res.char_value = 16'h0A;
						16'h72: res.char_value = 16'h0D;
						16'h74: res.char_value = 16'h09;
						16'h75: begin
							res.char_valid = 1'b0;
							st_nxt.hex_accum = '0;
							st_nxt.hex_count = 2'd0;
							np = PH_HEX;
						end
						default: begin
							res.char_valid = 1'b0;
							np = PH_ESC;
							err = ERR_BAD_ESCAPE;
						end
					endcase
				end
				PH_HEX: begin
					if (!hv[4]) begin
						err = ERR_BAD_ESCAPE;
					end else if (st.hex_count == 2'd3) begin
						res.char_valid = 1'b1;
						res.char_value = acc;
						st_nxt.hex_accum = '0;
						st_nxt.hex_count = 2'd0;
						np = PH_STR;
					end else begin
						st_nxt.hex_accum = acc;
						st_nxt.hex_count = st.hex_count + 2'd1;
					end
				end
				PH_NSIGN: begin
					if (is_digit(ch)) begin
						np = PH_NINT;
					end else begin
						err = ERR_BAD_NUMBER;
					end
				end
				PH_NINT: begin
					if (ch == 16'h2E) begin
						np = PH_NFRAC0;
					end else if (c_e) begin
						np = PH_NEXP0;
					end
				end
				PH_NFRAC0: begin
					if (is_digit(ch)) begin
						np = PH_NFRAC;
					end else begin
						err = ERR_BAD_NUMBER;
					end
				end
				PH_NFRAC: begin
					if (c_e) begin
						np = PH_NEXP0;
					end
				end
				PH_NEXP0: begin
					if (ch == 16'h2B || ch == 16'h2D) begin
						np = PH_NEXPS;
					end else if (is_digit(ch)) begin
						np = PH_NEXP;
					end else begin
						err = ERR_BAD_NUMBER;
					end
				end
				PH_NEXPS: begin
					if (is_digit(ch)) begin
						np = PH_NEXP;
					end else begin
						err = ERR_BAD_NUMBER;
					end
				end
				PH_NEXP: begin
					np = PH_NEXP;
				end
				PH_LIT_T, PH_LIT_F, PH_LIT_N: begin
					if (ch == {8'h00, lit_char(p, st.lit_idx)} &&
						!(p != PH_LIT_F && st.lit_idx == 3'd4)) begin
						if ((p == PH_LIT_F && st.lit_idx == 3'd4) ||
							(p != PH_LIT_F && st.lit_idx == 3'd3)) begin
							st_nxt.lit_idx = 3'd0;
							if (depth == '0) begin
								res.value_done = 1'b1;
								np = PH_IDLE;
							end else begin
								np = PH_AFTER;
							end
						end else begin
							st_nxt.lit_idx = st.lit_idx + 3'd1;
						end
					end else begin
						err = (p == PH_LIT_N) ? ERR_BAD_NULL : ERR_BAD_BOOL;
					end
				end
				default: np = PH_IDLE;
			endcase

			if (op.pop) begin
				dn = (depth != '0) ? depth - 1'b1 : depth;
				tn = below;
				if (dn == '0) begin
					res.value_done = 1'b1;
					np = PH_IDLE;
				end else begin
					np = PH_AFTER;
				end
			end
			if (res.char_valid) begin
				res.char_is_key = st.in_key;
			end

			if (last && err == ERR_NONE) begin
				if (np == PH_NINT || np == PH_NFRAC || np == PH_NEXP) begin
					if (dn == '0) begin
						res.value_done = 1'b1;
						np = PH_IDLE;
					end else begin
						np = PH_AFTER;
					end
				end
				case (np)
					PH_IDLE: err = ERR_NONE;
					PH_VALUE, PH_VAL_OR_ACLOSE: err = ERR_VALUE_OVF;
					PH_KEY_OR_OCLOSE, PH_KEY: err = ERR_EXP_STRING;
					PH_COLON: err = ERR_NO_COLON;
					PH_AFTER: err = (dn != '0 && tn) ? ERR_OBJECT_END : ERR_ARRAY_END;
					PH_STR: err = ERR_UNTERM_STR;
					PH_ESC, PH_HEX: err = ERR_BAD_ESCAPE;
					PH_LIT_T, PH_LIT_F: err = ERR_BAD_BOOL;
					PH_LIT_N: err = ERR_BAD_NULL;
					default: err = ERR_BAD_NUMBER;
				endcase
			end
			st_nxt.phase = np;
			st_nxt.err = err;
			res.error_code = err;
		end else begin
			res.error_code = st.err;
		end

		depth_nxt = dn;
		top_nxt = tn;
		if (last) begin
			st_nxt = '{phase: PH_IDLE, hex_accum: '0, hex_count: '0, lit_idx: '0,
				in_key: 1'b0, err: ERR_NONE};
			depth_nxt = '0;
			top_nxt = 1'b0;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/json_value_stream_validator_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// json_value_stream_validator_top
// Streaming JSON value validator, one UTF-16 character per transaction.
// ----------------------------------------------------------------------------
// Characters enter on the s_ channel (s_tdata holds the code unit, s_tlast
// marks the final character of a buffer). Every input transaction produces
// exactly one result transaction on the m_ channel, carrying the decoded
// string character, key and string-end flags, value completion, the nesting
// depth after the character and the sticky error code.
// The character is decoded and the parser state updated in the cycle it is
// accepted and the result registered. Throughput is one character per cycle
// without a receiver stall, set by the single result register and the nesting
// stack RAM, whose registered read always prefetches the entry below the top.
// s_tready stays high while the result register is empty or being drained,
// so a stalled receiver holds the result in place and the input waits until
// that result is taken. Reset clears the parser to expect a top-level value
// with an empty stack; no clearing pass is needed. After a transaction marked
// last the parser returns to that same state.
// ----------------------------------------------------------------------------
module json_value_stream_validator_top import jvsv_pkg::*; #(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,  // ch[15:0]
	input  wire logic        s_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// char_valid[0], char_value[16:1], char_is_key[17], string_end[18],
	// value_done[19], nest_depth[26:20], error_code[30:27], zero[31]
	output logic [31:0]      m_tdata
);

	localparam int DW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH > 1 ? STACK_DEPTH : 2);

	state_t        st_q, st_nxt;
	logic [DW-1:0] depth_q, depth_nxt, depth_rd, depth_rep;
	logic          top_q, top_nxt, below;
	stack_op_t     op;
	res_t          res;
	logic          accept;
	logic [31:0]   m_tdata_q;
	logic          m_tvalid_q;

	assign s_tready = !m_tvalid_q || m_tready;
	assign accept = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

	jvsv_step #(.STACK_DEPTH(STACK_DEPTH)) u_step (
		.st(st_q),
		.depth(depth_q),
		.top(top_q),
		.below(below),
		.ch(s_tdata),
		.last(s_tlast),
		.st_nxt(st_nxt),
		.depth_nxt(depth_nxt),
		.top_nxt(top_nxt),
		.op(op),
		.res(res)
	);

	// The read port always points two below the depth of the next cycle, so
	// the entry that becomes the top after a pop is ready when needed.
	assign depth_rd = (accept ? depth_nxt : depth_q) - DW'(2);

	jvsv_ram #(.WIDTH(1), .DEPTH(STACK_DEPTH)) u_stack (
		.clk(clk),
		.we(accept && op.push),
		.waddr(depth_q[AW-1:0]),
		.wdata(op.kind),
		.raddr(depth_rd[AW-1:0]),
		.rdata(below)
	);

	// Depth reported for a character, taken before the end-of-buffer reset.
	always_comb begin
		depth_rep = depth_q;
		if (op.push) begin
			depth_rep = depth_q + 1'b1;
		end else if (op.pop && depth_q != '0) begin
			depth_rep = depth_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{phase: PH_IDLE, hex_accum: '0, hex_count: '0, lit_idx: '0,
				in_key: 1'b0, err: ERR_NONE};
			depth_q <= '0;
			top_q <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (accept) begin
				st_q <= st_nxt;
				depth_q <= depth_nxt;
				top_q <= top_nxt;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_tdata_q <= {1'b0, res.error_code, NEST_W'(depth_rep),
				res.value_done, res.string_end, res.char_is_key, res.char_value,
				res.char_valid};
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) depth_q <= DW'(STACK_DEPTH))
		else $error("nesting depth beyond stack size");
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && s_tlast |=> depth_q == '0 && st_q.err == ERR_NONE)
		else $error("state not cleared after last character");
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && !s_tlast && st_q.err != ERR_NONE |=> $stable(depth_q))
		else $error("depth moved while error is sticky");
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !(op.push && op.pop))
		else $error("push and pop on one character");
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && st_q.err == ERR_NONE && !s_tlast |=> m_tdata_q[26:20] == NEST_W'(depth_q))
		else $error("reported depth differs from stack depth");

endmodule
`default_nettype wire

// ----- bench/jvsv_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jvsv_checker
// Watches both channels of the JSON validator, predicts each result and
// compares it field by field with what the block delivers.
// ----------------------------------------------------------------------------
module jvsv_checker import jvsv_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [15:0] s_tdata,
	input  wire logic        s_tlast,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [31:0] m_tdata,
	output int               fail_count,
	output int               results_owed
);

	localparam int NEST_MAX = STACK_DEPTH_DEF;

	// Parser state as predicted.
	phase_t          ph;
	logic [NEST_MAX-1:0] kinds;
	int unsigned     depth;
	logic [15:0]     hacc;
	int unsigned     hcnt;
	int unsigned     lidx;
	logic            key_mode;
	err_t            err;

	// Result fields of the character being predicted.
	logic        r_valid, r_key, r_send, r_done;
	logic [15:0] r_value;

	logic [31:0] expected_results[$];

	assign results_owed = expected_results.size();

	function automatic logic ws(logic [15:0] c);
		return c == 16'h20 || c == 16'h09 || c == 16'h0D || c == 16'h0A;
	endfunction

	function automatic logic dig(logic [15:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic [7:0] word_at(phase_t p, int unsigned i);
		string w;
		w = (p == PH_LIT_T) ? "true" : (p == PH_LIT_F) ? "false" : "null";
		return (i < w.len()) ? w[i] : 8'h00;
	endfunction

	function automatic void parser_clear();
		ph = PH_IDLE;
		kinds = '0;
		depth = 0;
		hacc = '0;
		hcnt = 0;
		lidx = 0;
		key_mode = 1'b0;
		err = ERR_NONE;
	endfunction

	function automatic void raise(err_t e);
		if (err == ERR_NONE) err = e;
	endfunction

	function automatic logic in_object();
		return depth != 0 && depth <= NEST_MAX && kinds[depth-1];
	endfunction

	function automatic void value_complete();
		if (depth == 0) begin
			r_done = 1'b1;
			ph = PH_IDLE;
		end else begin
			ph = PH_AFTER;
		end
	endfunction

	function automatic void open_nest(logic kind, phase_t nxt);
		if (depth >= NEST_MAX) begin
			raise(ERR_VALUE_OVF);
		end else begin
			kinds[depth] = kind;
			depth++;
			ph = nxt;
		end
	endfunction

	function automatic void close_nest();
		if (depth > 0) depth--;
		value_complete();
	endfunction

	function automatic void put_char(logic [15:0] c);
		r_valid = 1'b1;
		r_value = c;
		r_key = key_mode;
	endfunction

	function automatic logic [4:0] hex_digit(logic [15:0] c);
		if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
		if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 10)};
		if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 10)};
		return 5'd0;
	endfunction

	// Returns 1 when a finished number hands the character on to the new phase.
	function automatic logic consume(logic [15:0] c);
		logic [4:0] h;
		case (ph)
			PH_IDLE, PH_VALUE, PH_VAL_OR_ACLOSE: begin
				if (ws(c)) return 1'b0;
				if (ph == PH_VAL_OR_ACLOSE && c == "]") close_nest();
				else if (c == "{") open_nest(1'b1, PH_KEY_OR_OCLOSE);
				else if (c == "[") open_nest(1'b0, PH_VAL_OR_ACLOSE);
				else if (c == "\"") begin
					key_mode = 1'b0;
					ph = PH_STR;
				end else if (c == "t") begin
					lidx = 1;
					ph = PH_LIT_T;
				end else if (c == "f") begin
					lidx = 1;
					ph = PH_LIT_F;
				end else if (c == "n") begin
					lidx = 1;
					ph = PH_LIT_N;
				end else if (c == "-") ph = PH_NSIGN;
				else if (dig(c)) ph = PH_NINT;
				else raise(ERR_VALUE_OVF);
			end
			PH_KEY_OR_OCLOSE, PH_KEY: begin
				if (ws(c)) return 1'b0;
				if (ph == PH_KEY_OR_OCLOSE && c == "}") close_nest();
				else if (c == "\"") begin
					key_mode = 1'b1;
					ph = PH_STR;
				end else raise(ERR_EXP_STRING);
			end
			PH_COLON: begin
				if (ws(c)) return 1'b0;
				if (c == ":") ph = PH_VALUE;
				else raise(ERR_NO_COLON);
			end
			PH_AFTER: begin
				if (ws(c)) return 1'b0;
				if (c == ",") ph = in_object() ? PH_KEY : PH_VALUE;
				else if (in_object()) begin
					if (c == "}") close_nest();
					else raise(ERR_OBJECT_END);
				end else begin
					if (c == "]") close_nest();
					else raise(ERR_ARRAY_END);
				end
			end
			PH_STR: begin
				if (c == "\\") ph = PH_ESC;
				else if (c == "\"") begin
					r_send = 1'b1;
					if (key_mode) begin
						key_mode = 1'b0;
						ph = PH_COLON;
					end else value_complete();
				end else put_char(c);
			end
			PH_ESC: begin
				ph = PH_STR;
				case (c)
					"\"", "\\", "/": put_char(c);
					"b": put_char(CH_BS);
					"f": put_char(CH_FF);
					"n": put_char(16'h0A);
					"r": put_char(16'h0D);
					"t": put_char(16'h09);
					"u": begin
						hacc = '0;
						hcnt = 0;
						ph = PH_HEX;
					end
					default: raise(ERR_BAD_ESCAPE);
				endcase
			end
			PH_HEX: begin
				h = hex_digit(c);
				if (!h[4]) begin
					raise(ERR_BAD_ESCAPE);
				end else begin
					hacc = {hacc[11:0], h[3:0]};
					if (hcnt >= 3) begin
						put_char(hacc);
						hcnt = 0;
						hacc = '0;
						ph = PH_STR;
					end else hcnt++;
				end
			end
			PH_NSIGN, PH_NFRAC0, PH_NEXPS: begin
				if (!dig(c)) raise(ERR_BAD_NUMBER);
				else ph = (ph == PH_NFRAC0) ? PH_NFRAC : (ph == PH_NSIGN) ? PH_NINT : PH_NEXP;
			end
			PH_NEXP0: begin
				if (c == "+" || c == "-") ph = PH_NEXPS;
				else if (dig(c)) ph = PH_NEXP;
				else raise(ERR_BAD_NUMBER);
			end
			PH_NINT, PH_NFRAC, PH_NEXP: begin
				if (dig(c)) return 1'b0;
				if (ph == PH_NINT && c == ".") begin
					ph = PH_NFRAC0;
					return 1'b0;
				end
				if (ph != PH_NEXP && (c == "e" || c == "E")) begin
					ph = PH_NEXP0;
					return 1'b0;
				end
				value_complete();
				return 1'b1;
			end
			PH_LIT_T, PH_LIT_F, PH_LIT_N: begin
				if (c == {8'h00, word_at(ph, lidx)}) begin
					lidx++;
					if (word_at(ph, lidx) == 8'h00) begin
						lidx = 0;
						value_complete();
					end
				end else raise(ph == PH_LIT_N ? ERR_BAD_NULL : ERR_BAD_BOOL);
			end
			default: ph = PH_IDLE;
		endcase
		return 1'b0;
	endfunction

	function automatic void buffer_end();
		if (ph == PH_NINT || ph == PH_NFRAC || ph == PH_NEXP) value_complete();
		case (ph)
			PH_IDLE: ;
			PH_VALUE, PH_VAL_OR_ACLOSE: raise(ERR_VALUE_OVF);
			PH_KEY_OR_OCLOSE, PH_KEY: raise(ERR_EXP_STRING);
			PH_COLON: raise(ERR_NO_COLON);
			PH_AFTER: raise(in_object() ? ERR_OBJECT_END : ERR_ARRAY_END);
			PH_STR: raise(ERR_UNTERM_STR);
			PH_ESC, PH_HEX: raise(ERR_BAD_ESCAPE);
			PH_LIT_T, PH_LIT_F: raise(ERR_BAD_BOOL);
			PH_LIT_N: raise(ERR_BAD_NULL);
			default: raise(ERR_BAD_NUMBER);
		endcase
	endfunction

	function automatic logic [31:0] parse_char(logic [15:0] c, logic fin);
		logic [31:0] r;
		r_valid = 1'b0;
		r_value = '0;
		r_key = 1'b0;
		r_send = 1'b0;
		r_done = 1'b0;
		if (err == ERR_NONE) begin
			if (consume(c) && err == ERR_NONE) void'(consume(c));
		end
		if (fin && err == ERR_NONE) buffer_end();
		r = {1'b0, err, 7'(depth), r_done, r_send, r_key, r_value, r_valid};
		if (fin) parser_clear();
		return r;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
		fail_count++;
	endtask

	// The parser starts from its reset state even when reset shows no edge.
	initial begin
		fail_count = 0;
		parser_clear();
	end

	always @(posedge clk or negedge arst_n) begin
		logic [31:0] want;
		if (!arst_n) begin
			parser_clear();
			expected_results.delete();
		end else begin
			if (s_tvalid && s_tready)
				expected_results = {expected_results, parse_char(s_tdata, s_tlast)};
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					report("unexpected result", m_tdata, 32'h0);
				end else begin
					want = expected_results.pop_front();
					if (m_tdata[0] !== want[0]) report("char_valid", m_tdata[0], want[0]);
					if (m_tdata[16:1] !== want[16:1])
						report("char_value", m_tdata[16:1], want[16:1]);
					if (m_tdata[17] !== want[17]) report("char_is_key", m_tdata[17], want[17]);
					if (m_tdata[18] !== want[18]) report("string_end", m_tdata[18], want[18]);
					if (m_tdata[19] !== want[19]) report("value_done", m_tdata[19], want[19]);
					if (m_tdata[26:20] !== want[26:20])
						report("nest_depth", m_tdata[26:20], want[26:20]);
					if (m_tdata[30:27] !== want[30:27])
						report("error_code", m_tdata[30:27], want[30:27]);
					if (m_tdata[31] !== 1'b0) report("pad bit", m_tdata[31], 1'b0);
				end
			end
		end
	end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Feeds JSON text, well-formed and damaged, into the validator with random
// gaps and receiver stalls; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int LIMIT = 300000;
	localparam int RANDOM_ITEMS = 1050;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;

	int fail_count;
	int results_owed;
	int cycles = 0;
	int sent = 0;
	bit calm = 1'b0;

	logic [15:0] text_chars[$];
	bit          text_ends[$];

	json_value_stream_validator_top uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	jvsv_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.fail_count(fail_count), .results_owed(results_owed)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic put(logic [15:0] c);
		text_chars = {text_chars, c};
		text_ends = {text_ends, 1'b0};
	endtask

	task automatic put_text(string s, bit fin);
		foreach (s[i]) put({8'h00, s[i]});
		if (fin) text_ends[$] = 1'b1;
	endtask

	task automatic put_blank();
		int n;
		string w;
		n = $urandom_range(0, 2);
		w = " \t\r\n";
		repeat (n) put({8'h00, w[$urandom_range(0, 3)]});
	endtask

	task automatic put_hex();
		string d;
		d = "0123456789abcdefABCDEF";
		put({8'h00, d[$urandom_range(0, 21)]});
	endtask

	task automatic put_string();
		int n;
		logic [15:0] c;
		string esc;
		esc = "\"\\/bfnrt";
		put("\"");
		n = $urandom_range(0, 5);
		repeat (n) begin
			case ($urandom_range(0, 5))
				0, 1: put(16'($urandom_range(16'h20, 16'h7E)));
				2: begin
					c = 16'($urandom);
					if (c == "\"" || c == "\\") c = 16'hFFFF;
					put(c);
				end
				3, 4: begin
					put("\\");
					put({8'h00, esc[$urandom_range(0, 7)]});
				end
				default: begin
					put("\\");
					put("u");
					repeat (4) put_hex();
				end
			endcase
		end
		put("\"");
	endtask

	task automatic put_number();
		if ($urandom_range(0, 1)) put("-");
		repeat ($urandom_range(1, 3)) put(16'($urandom_range("0", "9")));
		if ($urandom_range(0, 1)) begin
			put(".");
			repeat ($urandom_range(1, 2)) put(16'($urandom_range("0", "9")));
		end
		if ($urandom_range(0, 2) == 0) begin
			put($urandom_range(0, 1) ? "e" : "E");
			case ($urandom_range(0, 2))
				0: put("+");
				1: put("-");
				default: ;
			endcase
			repeat ($urandom_range(1, 2)) put(16'($urandom_range("0", "9")));
		end
	endtask

	task automatic put_value(int level);
		int n;
		case ($urandom_range(level < 4 ? 0 : 2, 6))
			0: begin
				put("{");
				put_blank();
				n = $urandom_range(0, 3);
				for (int i = 0; i < n; i++) begin
					if (i > 0) begin
						put(",");
						put_blank();
					end
					put_string();
					put_blank();
					put(":");
					put_blank();
					put_value(level + 1);
					put_blank();
				end
				put("}");
			end
			1: begin
				put("[");
				put_blank();
				n = $urandom_range(0, 3);
				for (int i = 0; i < n; i++) begin
					if (i > 0) begin
						put(",");
						put_blank();
					end
					put_value(level + 1);
					put_blank();
				end
				put("]");
			end
			2, 3: put_string();
			4: put_number();
			5: put_text($urandom_range(0, 1) ? "true" : "false", 1'b0);
			default: put_text("null", 1'b0);
		endcase
	endtask

	// One buffer of one to three values; a quarter of them get damaged.
	task automatic put_buffer();
		int first, span, pos;
		string noise;
		noise = "{}[]:,\"\\ute0-.+x";
		first = text_chars.size();
		repeat ($urandom_range(1, 3)) begin
			put_blank();
			put_value(0);
			put(" ");
		end
		span = text_chars.size() - first;
		case ($urandom_range(0, 7))
			0: begin
				pos = first + $urandom_range(0, span - 1);
				text_chars[pos] = $urandom_range(0, 1) ? 16'($urandom)
					: {8'h00, noise[$urandom_range(0, noise.len() - 1)]};
			end
			1: begin
				pos = first + $urandom_range(0, span - 1);
				text_chars = text_chars[0:pos];
				text_ends = text_ends[0:pos];
			end
			default: ;
		endcase
		text_ends[$] = 1'b1;
	endtask

	task automatic build_stimulus();
		// Nested containers of every kind, all escapes, key flags.
		put_text("{\"k\\u00e9\":[1,-2.5e+3,0.0E-1,7e9,true,false,null],\"s\":\"\\b\\f\\n\\r\\t\\/\\\\\\\"\"}", 1'b1);
		// Extremes of the character range inside a string.
		put("\"");
		put(16'hFFFF);
		put(16'h0000);
		put(16'h0001);
		put_text("\\uFFFF\\uD800\"", 1'b1);
		put_text("007 12", 1'b1);        // leading zeros, number closed by the end
		put_text("[12]", 1'b1);          // number closed by a bracket
		put_text("[}", 1'b1);
		put_text("{]", 1'b1);
		put_text("{1", 1'b1);
		put_text("{\"a\" 1", 1'b1);
		put_text("tru x", 1'b1);
		put_text("nul", 1'b1);
		put_text("fals", 1'b1);
		put_text("-x", 1'b1);
		put_text("1.e", 1'b1);
		put_text("1e+", 1'b1);
		put_text("\"\\q\"", 1'b1);
		put_text("\"\\u12g4\"", 1'b1);
		put_text("\"open", 1'b1);
		put_text("[1,", 1'b1);
		put_text("{\"a\":1,", 1'b1);
		put_text(" ", 1'b1);
		put_text("@", 1'b1);
		// One more opening bracket than the stack holds.
		repeat (65) put("[");
		text_ends[$] = 1'b1;
		repeat (64) put("[");
		repeat (64) put("]");
		text_ends[$] = 1'b1;
		while (text_chars.size() < RANDOM_ITEMS) put_buffer();
	endtask

	// Sender: bursts of idle cycles, none over the closing stretch.
	initial begin
		bit took;
		build_stimulus();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < text_chars.size(); i++) begin
			calm = (i > text_chars.size() - 200);
			if (!calm && $urandom_range(0, 9) == 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata <= text_chars[i];
			s_tlast <= text_ends[i];
			do begin
				@(negedge clk);
				took = s_tready;
				@(posedge clk);
			end while (!took);
			sent++;
		end
		s_tvalid <= 1'b0;
		while (results_owed != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// Receiver: random stall bursts, one long hold-off, always ready at the end.
	initial begin
		bit held;
		held = 1'b0;
		@(posedge clk);
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!held && sent >= 400) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (150) @(posedge clk);
			end else if (calm) begin
				m_tready <= 1'b1;
				@(posedge clk);
			end else begin
				m_tready <= ($urandom_range(0, 2) != 0);
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
		end
	end

endmodule
